/* rtl/core/dics_pkg.sv */
// dics_pkg: types, constants and codes shared by the discrete inverse-cdf sampler
// used by dics_front, dics_queue, dics_back and discrete_inverse_cdf_sampler
// no dependencies
package dics_pkg;

    // default table size and fixed field widths
    localparam int C_TABLE_DEPTH  = 256;
    localparam int C_WEIGHT_BITS  = 16;
    localparam int C_WEIGHT_W     = 16;
    localparam int C_UNIFORM_W    = 32;
    localparam int C_TOTAL_W      = 24;
    localparam int C_INDEX_W      = 8;
    localparam int C_COUNT_W      = 9;
    localparam int C_QUEUE_DEPTH  = 2;
    localparam int C_PADDR_W      = 3;

    // low weight bits that take part in the sum
    localparam logic [C_WEIGHT_W-1:0] C_WEIGHT_MASK =
        C_WEIGHT_W'((33'd1 << C_WEIGHT_BITS) - 33'd1);

    // saturation value of the running total
    localparam logic [C_TOTAL_W-1:0] C_TOTAL_MAX = {C_TOTAL_W{1'b1}};

    // register map (word index taken from paddr[2])
    localparam logic C_REG_ENTRY_COUNT = 1'b0;

    // input item as it arrives on the port
    typedef struct packed {
        logic                   func;
        logic                   restart;
        logic [C_WEIGHT_W-1:0]  weight;
        logic [C_UNIFORM_W-1:0] uniform;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [C_INDEX_W-1:0] index;
        logic                 empty_total;
    } t_out_item;

    // command kinds after classification
    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_DRAW = 1'b1
    } t_cmd_kind;

    // classified command carried through the queue
    typedef struct packed {
        t_cmd_kind              kind;
        logic                   restart;
        logic [C_WEIGHT_W-1:0]  weight;
        logic [C_UNIFORM_W-1:0] uniform;
    } t_cmd;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // back-end sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_SEARCH,
        S_EMIT
    } t_back_state;

endpackage

/* rtl/core/dics_front.sv */
// dics_front: accepts input items, classifies them and masks the weight
// depends on dics_pkg; pushes into dics_queue
module dics_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  dics_pkg::t_in_item  i_in_data,
    input  dics_pkg::t_q_status i_q_status,
    output logic                o_push,
    output dics_pkg::t_cmd      o_push_data
);
    import dics_pkg::*;

    logic  r_valid, n_valid;
    t_cmd  r_cmd, n_cmd;
    logic  accept;

    // hold stage: stall only while it is full and the queue cannot take it
    assign o_in_stall  = r_valid && i_q_status.full;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_push      = r_valid && !i_q_status.full;
    assign o_push_data = r_cmd;

    // classify the incoming transfer
    always_comb begin
        n_cmd.kind    = i_in_data.func ? CMD_DRAW : CMD_LOAD;
        n_cmd.restart = i_in_data.restart;
        n_cmd.weight  = i_in_data.weight & C_WEIGHT_MASK;
        n_cmd.uniform = i_in_data.uniform;
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    // hold stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

/* rtl/core/dics_queue.sv */
// dics_queue: short command queue between front and back end
// depends on dics_pkg
module dics_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  dics_pkg::t_cmd      i_push_data,
    input  logic                i_pop,
    output dics_pkg::t_cmd      o_pop_data,
    output dics_pkg::t_q_status o_status
);
    import dics_pkg::*;

    localparam int PTR_W = (C_QUEUE_DEPTH > 1) ? $clog2(C_QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(C_QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(C_QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(C_QUEUE_DEPTH);

    t_cmd             r_slot [C_QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;
    logic             do_push, do_pop;

    assign o_status.full  = (r_count == FULL);
    assign o_status.empty = (r_count == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_pop_data     = r_slot[r_rd_ptr];

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

/* rtl/core/dics_back.sv */
// dics_back: executes loads into the prefix table and runs the binary search for draws
// depends on dics_pkg; fed by dics_queue
module dics_back #(
    parameter int TABLE_DEPTH = dics_pkg::C_TABLE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  dics_pkg::t_q_status               i_q_status,
    input  dics_pkg::t_cmd                    i_cmd,
    output logic                              o_pop,
    input  logic [dics_pkg::C_COUNT_W-1:0]    i_entry_count,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output dics_pkg::t_out_item               o_out_data
);
    import dics_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int PW = $clog2(TABLE_DEPTH + 1);
    localparam int PROD_W = C_UNIFORM_W + C_TOTAL_W;

    // prefix table
    logic [C_TOTAL_W-1:0] mem [TABLE_DEPTH];
    logic                 mem_we;
    logic [AW-1:0]        mem_wa;
    logic [C_TOTAL_W-1:0] mem_wd;
    logic [AW-1:0]        rd_addr;
    logic [C_TOTAL_W-1:0] r_rdata;

    t_back_state          r_state, n_state;
    logic [C_TOTAL_W-1:0] r_total, n_total;
    logic [PW-1:0]        r_pos, n_pos;
    logic [C_UNIFORM_W-1:0] r_uniform, n_uniform;
    logic [PROD_W-1:0]    r_target, n_target;
    logic [AW-1:0]        r_lo, n_lo;
    logic [PW-1:0]        r_hi, n_hi;
    logic [AW-1:0]        r_mid, n_mid;
    logic                 r_empty, n_empty;
    logic                 r_out_valid, n_out_valid;
    t_out_item            r_out, n_out;

    // load helpers
    logic [C_TOTAL_W-1:0] base_total;
    logic [PW-1:0]        base_pos;
    logic [C_TOTAL_W:0]   sum;

    // search helpers
    logic [31:0]          ec32, n32;
    logic [PW-1:0]        count_n;
    logic                 below;
    logic [PW-1:0]        mid_wide;
    logic [31:0]          lo32;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // clamp entry_count to one up to the table depth
    always_comb begin
        ec32 = 32'(i_entry_count);
        n32  = (ec32 == 32'd0) ? 32'd1 : ec32;
        if (n32 > 32'(TABLE_DEPTH)) begin
            n32 = 32'(TABLE_DEPTH);
        end
        count_n = PW'(n32);
    end

    // table entry below the scaled draw: prefix * 2^32 < uniform * total
    assign below = (r_rdata < r_target[PROD_W-1:C_UNIFORM_W]) ||
                   ((r_rdata == r_target[PROD_W-1:C_UNIFORM_W]) &&
                    (r_target[C_UNIFORM_W-1:0] != '0));

    assign lo32 = 32'(r_lo);

    // sequencer: next state, datapath and outputs
    always_comb begin
        n_state     = r_state;
        n_total     = r_total;
        n_pos       = r_pos;
        n_uniform   = r_uniform;
        n_target    = r_target;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_empty     = r_empty;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        o_pop       = 1'b0;
        mem_we      = 1'b0;
        mem_wa      = '0;
        mem_wd      = '0;
        rd_addr     = r_mid;
        base_total  = i_cmd.restart ? '0 : r_total;
        base_pos    = i_cmd.restart ? '0 : r_pos;
        sum         = {1'b0, base_total} + (C_TOTAL_W + 1)'(i_cmd.weight);
        mid_wide    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop = 1'b1;
                    if (i_cmd.kind == CMD_LOAD) begin
                        // append one weight; a full table ignores it
                        n_total = base_total;
                        n_pos   = base_pos;
                        if (32'(base_pos) < 32'(TABLE_DEPTH)) begin
                            mem_we  = 1'b1;
                            mem_wa  = AW'(base_pos);
                            mem_wd  = base_total;
                            n_total = sum[C_TOTAL_W] ? C_TOTAL_MAX : sum[C_TOTAL_W-1:0];
                            n_pos   = base_pos + PW'(1);
                        end
                    end else begin
                        n_uniform = i_cmd.uniform;
                        n_state   = S_PREP;
                    end
                end
            end

            S_PREP: begin
                // scale the draw and open the search window
                n_target = PROD_W'(r_uniform) * PROD_W'(r_total);
                n_lo     = '0;
                n_hi     = count_n;
                n_mid    = AW'(count_n >> 1);
                rd_addr  = n_mid;
                n_empty  = (r_total == '0);
                if ((r_total == '0) || (n_mid == '0)) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_SEARCH;
                end
            end

            S_SEARCH: begin
                // one halving step per cycle
                if (below) begin
                    n_lo = r_mid;
                end else begin
                    n_hi = PW'(r_mid);
                end
                mid_wide = PW'(n_lo) + ((n_hi - PW'(n_lo)) >> 1);
                n_mid    = AW'(mid_wide);
                rd_addr  = n_mid;
                if (n_mid == n_lo) begin
                    n_state = S_EMIT;
                end
            end

            S_EMIT: begin
                // hand the result to the output register once it is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid       = 1'b1;
                    n_out.index       = lo32[C_INDEX_W-1:0];
                    n_out.empty_total = r_empty;
                    n_state           = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_total     <= n_total;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
        r_uniform <= n_uniform;
        r_target  <= n_target;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_mid     <= n_mid;
        r_empty   <= n_empty;
        r_out     <= n_out;
    end

    // table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rdata <= mem[rd_addr];
    end

endmodule

/* rtl/core/discrete_inverse_cdf_sampler.sv */
// discrete_inverse_cdf_sampler: top level with configuration port, front end, queue, back end
// depends on dics_pkg, dics_front, dics_queue, dics_back
//
// Draws an index from a discrete distribution held as a table of exclusive
// prefix sums. A load item (func 0) appends one weight in the back end;
// restart begins again at entry zero with the total cleared, and loads past the
// table depth are dropped. A draw item (func 1) passes through the back end in
// steps: the pop, forming uniform * total on the 32x24 multiplier, the
// binary-search steps (each one read of the single prefix-table read port and one
// exact compare), and placing the result in the output register. A zero total
// skips the search and answers with index 0 and empty_total set. Loads and draws
// queue behind a one-item hold stage and a two-entry command queue, so up to
// three further items wait for the back end while it holds a draw result that the
// output stalls. entry_count lives at byte address 0; the user must write it only
// while the block is idle, and the block itself does not enforce this.
module discrete_inverse_cdf_sampler #(
    parameter int TABLE_DEPTH = dics_pkg::C_TABLE_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  dics_pkg::t_in_item               i_in_data,
    // output channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output dics_pkg::t_out_item              o_out_data,
    // configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [dics_pkg::C_PADDR_W-1:0]   paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import dics_pkg::*;

    logic [C_COUNT_W-1:0] r_entry_count;
    logic                 cfg_wr;
    logic                 push;
    t_cmd                 push_data;
    logic                 pop;
    t_cmd                 pop_data;
    t_q_status            q_status;

    // configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= C_COUNT_W'(1);
        end else if (cfg_wr && (paddr[2] == C_REG_ENTRY_COUNT)) begin
            r_entry_count <= pwdata[C_COUNT_W-1:0];
        end
    end

    // register read back
    always_comb begin
        if (paddr[2] == C_REG_ENTRY_COUNT) begin
            prdata = 32'(r_entry_count);
        end else begin
            prdata = '0;
        end
    end

    // accept and classify
    dics_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_push_data (push_data)
    );

    // command queue
    dics_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_pop_data  (pop_data),
        .o_status    (q_status)
    );

    // table update and search
    dics_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_status    (q_status),
        .i_cmd         (pop_data),
        .o_pop         (pop),
        .i_entry_count (r_entry_count),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_data    (o_out_data)
    );

endmodule
